>>> rtl/lmpf_pkg.sv
// lmpf_pkg: shared constants, register codes and sine table builder
// for the lidar median polar filter; no dependencies

package lmpf_pkg;

  typedef enum logic [1:0] {
    CFG_RANGE_MIN  = 2'd0,
    CFG_RANGE_MAX  = 2'd1,
    CFG_ANGLE_STEP = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] RANGE_MIN_RESET  = 32'd0;
  localparam logic [31:0] RANGE_MAX_RESET  = 32'd65535;
  localparam logic [31:0] ANGLE_STEP_RESET = 32'd64;

  // pi/2 in q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q15_MAX     = 64'd32767;

  // taylor series of sin up to x^15, x in q30, result q0.15 capped
  function automatic logic [14:0] sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] mag;
    logic [63:0] sum;
    logic [63:0] v;
    x2  = (x * x) >> 30;
    mag = x;
    sum = x;
    mag = ((mag * x2) >> 30) / 64'd6;
    sum = sum - mag;
    mag = ((mag * x2) >> 30) / 64'd20;
    sum = sum + mag;
    mag = ((mag * x2) >> 30) / 64'd42;
    sum = sum - mag;
    mag = ((mag * x2) >> 30) / 64'd72;
    sum = sum + mag;
    mag = ((mag * x2) >> 30) / 64'd110;
    sum = sum - mag;
    mag = ((mag * x2) >> 30) / 64'd156;
    sum = sum + mag;
    mag = ((mag * x2) >> 30) / 64'd210;
    sum = sum - mag;
    v = (sum + (64'd1 << 14)) >> 15;
    if (v > Q15_MAX) begin
      v = Q15_MAX;
    end
    return v[14:0];
  endfunction

endpackage

>>> rtl/lmpf_if.sv
// lmpf_if: valid/ready channel interfaces for range samples and points
// depends on nothing

interface lmpf_in_if #(
  parameter int RANGE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_mm;
  logic                  first_sample;
  logic                  last_sample;

  modport source (output valid, range_mm, first_sample, last_sample, input ready);
  modport sink   (input valid, range_mm, first_sample, last_sample, output ready);
endinterface

interface lmpf_out_if #(
  parameter int RANGE_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [RANGE_BITS:0] x_mm;
  logic signed [RANGE_BITS:0] y_mm;
  logic                       point_valid;
  logic                       scan_end;

  modport source (output valid, x_mm, y_mm, point_valid, scan_end, input ready);
  modport sink   (input valid, x_mm, y_mm, point_valid, scan_end, output ready);
endinterface

>>> rtl/lmpf_polar.sv
// lmpf_polar: quarter-wave sine lookup and range scaling to x/y
// depends on lmpf_pkg

module lmpf_polar import lmpf_pkg::*; #(
  parameter int RANGE_BITS       = 16,
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic [RANGE_BITS-1:0]      r_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  logic                       keep_i,
  output logic signed [RANGE_BITS:0] x_o,
  output logic signed [RANGE_BITS:0] y_o
);

  localparam int IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int OffW  = PHASE_BITS - 2;
  localparam int ProdW = OffW + IdxW;
  localparam int MulW  = RANGE_BITS + 18;
  localparam logic [PHASE_BITS-1:0] Quarter = {2'b01, {OffW{1'b0}}};

  logic [14:0] sine_tab [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] X = HALF_PI_Q30 * k / SINE_TABLE_DEPTH;
    assign sine_tab[k] = sine_q15(X);
  end

  logic [PHASE_BITS-1:0]      ph   [2];
  logic [ProdW-1:0]           prod [2];
  logic [IdxW-1:0]            idx  [2];
  logic [IdxW-1:0]            tidx [2];
  logic [14:0]                mag  [2];
  logic signed [15:0]         s    [2];
  logic signed [MulW-1:0]     p    [2];
  logic signed [RANGE_BITS:0] res  [2];

  // lane 0 is cosine, lane 1 is sine
  always_comb begin
    ph[0] = phase_i + Quarter;
    ph[1] = phase_i;
    for (int c = 0; c < 2; c++) begin
      prod[c] = ProdW'(ph[c][OffW-1:0]) * ProdW'(SINE_TABLE_DEPTH);
      idx[c]  = prod[c][OffW +: IdxW];
      tidx[c] = ph[c][OffW] ? IdxW'(SINE_TABLE_DEPTH) - idx[c] : idx[c];
      mag[c]  = sine_tab[tidx[c]];
      s[c]    = ph[c][OffW+1] ? -$signed({1'b0, mag[c]}) : $signed({1'b0, mag[c]});
      p[c]    = MulW'($signed({1'b0, r_i})) * MulW'(s[c]) + MulW'(16384);
      // rounded division by 32768
      res[c]  = p[c][15 +: RANGE_BITS+1];
    end
  end

  assign x_o = keep_i ? res[0] : '0;
  assign y_o = keep_i ? res[1] : '0;

endmodule

>>> rtl/lidar_median_polar_filter_core.sv
// lidar_median_polar_filter_core: 3-point median on range samples, polar to x/y
// a first or last sample's job is queued at its transaction, a middle sample's median
// job at the next transaction, ahead of a last job; each is then registered at the output
// throughput: one sample per cycle unless the output stalls or a sample closes a middle
// and a scan; reset clears scan state, phase to a quarter turn and registers to defaults
// depends on lmpf_pkg, lmpf_if, lmpf_polar

module lidar_median_polar_filter_core import lmpf_pkg::*; #(
  parameter  int RANGE_BITS       = 16,
  parameter  int PHASE_BITS       = 16,
  parameter  int SINE_TABLE_DEPTH = 256,
  localparam int CfgW = (RANGE_BITS > PHASE_BITS) ? RANGE_BITS : PHASE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  lmpf_in_if.sink          sample_i,
  lmpf_out_if.source       point_o
);

  localparam int OffW = PHASE_BITS - 2;
  localparam logic [PHASE_BITS-1:0] Quarter = {2'b01, {OffW{1'b0}}};

  typedef struct packed {
    logic [RANGE_BITS-1:0] r;
    logic [PHASE_BITS-1:0] phase;
    logic                  keep;
    logic                  last;
  } job_t;

  logic [RANGE_BITS-1:0] rmin_q, rmax_q;
  logic [PHASE_BITS-1:0] step_q;
  logic [RANGE_BITS-1:0] prev_q, prev_d, older_q, older_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  pending_q, pending_d;
  logic [1:0]            cnt_q, cnt_d, new_cnt;
  job_t                  job_q [2];
  job_t                  job_d [2];
  job_t                  new_job [2];

  logic                  acc, pop;
  logic [RANGE_BITS-1:0] r_in, lo, hi, mh, med;
  logic [PHASE_BITS-1:0] phase_adv;
  logic                  keep_in, keep_prev;

  logic                       out_vld_q;
  logic signed [RANGE_BITS:0] x_q, y_q, x_c, y_c;
  logic                       pv_q, end_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= RANGE_BITS'(RANGE_MIN_RESET);
      rmax_q <= RANGE_BITS'(RANGE_MAX_RESET);
      step_q <= PHASE_BITS'(ANGLE_STEP_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_MIN:  rmin_q <= cfg_data_i[RANGE_BITS-1:0];
        CFG_RANGE_MAX:  rmax_q <= cfg_data_i[RANGE_BITS-1:0];
        CFG_ANGLE_STEP: step_q <= cfg_data_i[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign acc  = sample_i.valid && sample_i.ready;
  assign pop  = (cnt_q != 2'd0) && (!out_vld_q || point_o.ready);
  assign sample_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  assign r_in = sample_i.range_mm;

  // median of older, prev and current raw ranges
  always_comb begin
    lo  = (older_q < prev_q) ? older_q : prev_q;
    hi  = (older_q < prev_q) ? prev_q : older_q;
    mh  = (hi < r_in) ? hi : r_in;
    med = (lo > mh) ? lo : mh;
  end

  assign keep_in   = (r_in > rmin_q) && (r_in < rmax_q);
  assign keep_prev = (prev_q > rmin_q) && (prev_q < rmax_q);
  assign phase_adv = phase_q + step_q;

  // jobs raised by the incoming sample
  always_comb begin
    new_job[0] = '{r: r_in, phase: phase_adv, keep: keep_in, last: 1'b1};
    new_job[1] = new_job[0];
    new_cnt    = 2'd0;
    pending_d  = pending_q;
    phase_d    = phase_q;
    if (sample_i.first_sample) begin
      new_job[0] = '{r: r_in, phase: Quarter, keep: keep_in, last: sample_i.last_sample};
      new_cnt    = 2'd1;
      pending_d  = 1'b0;
      phase_d    = Quarter;
    end else begin
      phase_d   = phase_adv;
      pending_d = !sample_i.last_sample;
      if (pending_q) begin
        new_job[0] = '{r: med, phase: phase_q, keep: keep_prev, last: 1'b0};
        new_job[1] = '{r: r_in, phase: phase_adv, keep: keep_in, last: 1'b1};
        new_cnt    = sample_i.last_sample ? 2'd2 : 2'd1;
      end else begin
        new_cnt    = sample_i.last_sample ? 2'd1 : 2'd0;
      end
    end
  end

  assign older_d = prev_q;
  assign prev_d  = r_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      older_q   <= '0;
      phase_q   <= Quarter;
      pending_q <= 1'b0;
    end else if (acc) begin
      prev_q    <= prev_d;
      older_q   <= older_d;
      phase_q   <= phase_d;
      pending_q <= pending_d;
    end
  end

  // job queue, empty or draining whenever a transaction is taken
  always_comb begin
    cnt_d    = cnt_q;
    job_d[0] = job_q[0];
    job_d[1] = job_q[1];
    if (acc) begin
      cnt_d = new_cnt;
      job_d = new_job;
    end else if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      job_d[0] = job_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  lmpf_polar #(
    .RANGE_BITS      (RANGE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_polar (
    .r_i    (job_q[0].r),
    .phase_i(job_q[0].phase),
    .keep_i (job_q[0].keep),
    .x_o    (x_c),
    .y_o    (y_c)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop) begin
      out_vld_q <= 1'b1;
    end else if (point_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      x_q   <= x_c;
      y_q   <= y_c;
      pv_q  <= job_q[0].keep;
      end_q <= job_q[0].last;
    end
  end

  assign point_o.valid       = out_vld_q;
  assign point_o.x_mm        = x_q;
  assign point_o.y_mm        = y_q;
  assign point_o.point_valid = pv_q;
  assign point_o.scan_end    = end_q;

`ifndef SYNTH
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("job queue overfilled");

  a_first_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && sample_i.first_sample |=> cnt_q == 2'd1 && job_q[0].phase == Quarter)
    else $error("first sample job not at quarter turn");

  a_two_jobs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !sample_i.first_sample && pending_q && sample_i.last_sample
    |=> cnt_q == 2'd2 && job_q[1].last && !job_q[0].last)
    else $error("closing sample did not queue median and last jobs");

  a_dropped_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !pv_q |-> x_q == '0 && y_q == '0)
    else $error("point not kept but coordinates nonzero");
`endif

endmodule
